// File: hw/rtl/mbrpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrpt_pkg
// shared types for the bitmap row-to-page transpose block
// ----------------------------------------------------------------------------
package mbrpt_pkg;

  // input transaction: one byte of a bitmap row
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       frame_start;
  } mbrpt_in_t;

  // output transaction: eight column bytes of one page
  typedef struct packed {
    logic [63:0] column_bytes;
    logic [2:0]  page_index;
    logic [3:0]  group_index;
    logic        last_of_page;
    logic        last_of_frame;
  } mbrpt_out_t;

  // side information that goes with an assembled word
  typedef struct packed {
    logic [2:0] page_index;
    logic [3:0] group_index;
    logic       last_of_page;
    logic       last_of_frame;
  } mbrpt_meta_t;

  // control from the sequencer to the column assembler
  typedef struct packed {
    logic       load;
    logic [2:0] row;
  } mbrpt_asm_ctrl_t;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_LAST = 4'b0100,
    ST_PUT  = 4'b1000
  } mbrpt_state_e;

  localparam int unsigned RowsPerPage = 8;

endpackage

// File: hw/rtl/mono_bitmap_row_to_page_transpose_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_bitmap_row_to_page_transpose_top
// converts row-major monochrome bitmap bytes into vertical page format
// ----------------------------------------------------------------------------
// The block takes a COLUMNS x (8*PAGES) monochrome bitmap as row-major bytes,
// COLUMNS/8 bytes per row, leftmost pixel in the msb. A frame_start byte
// restarts the frame at page 0, row 0; after the last byte of the last page
// the position wraps on its own. Each byte is one input transaction and is
// taken in a single cycle into a one-page buffer ram. The last byte of a
// page starts the drain: for each group of eight columns the sequencer reads
// the eight row bytes of the group from the ram, one per cycle, and a shared
// bit-scatter unit folds them into eight column bytes (lsb = top row). One
// group takes eight ram reads, a read latency state and a handoff state
// into the output register, so a page drain holds input stall high through
// every group, and longer while the output side stalls. The output register
// lets the sequencer go on with the next group while a finished word waits
// to be taken.
// ----------------------------------------------------------------------------
module mono_bitmap_row_to_page_transpose_top #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mbrpt_pkg::mbrpt_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mbrpt_pkg::mbrpt_out_t out_data_o
);

  import mbrpt_pkg::*;

  localparam int unsigned PageBytes = (COLUMNS / 8) * RowsPerPage;
  localparam int unsigned AW = $clog2(PageBytes);

  // handshake
  logic in_fire;
  logic busy;
  logic slot_free;

  // buffer ram
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  // assembly and handoff
  mbrpt_asm_ctrl_t asm_ctrl;
  mbrpt_meta_t     meta;
  logic [63:0]     asm_word;
  logic            put;

  // output register
  logic       out_valid_q;
  mbrpt_out_t out_q;

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;

  // output register can take a word when empty or being drained this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  mbrpt_seq #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .frame_start_i (in_data_i.frame_start),
    .slot_free_i   (slot_free),
    .busy_o        (busy),
    .we_o          (we),
    .waddr_o       (waddr),
    .re_o          (re),
    .raddr_o       (raddr),
    .asm_ctrl_o    (asm_ctrl),
    .put_o         (put),
    .meta_o        (meta)
  );

  // one page of row bytes, row r of group g at r*COLUMNS/8 + g
  mbrpt_ram #(
    .WIDTH (8),
    .DEPTH (PageBytes)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.pixel_byte),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mbrpt_col_asm u_col_asm (
    .clk_i      (clk_i),
    .ctrl_i     (asm_ctrl),
    .row_byte_i (rdata),
    .word_o     (asm_word)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (put) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (put) begin
      out_q.column_bytes  <= asm_word;
      out_q.page_index    <= meta.page_index;
      out_q.group_index   <= meta.group_index;
      out_q.last_of_page  <= meta.last_of_page;
      out_q.last_of_frame <= meta.last_of_frame;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_accept_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && put) |-> !in_fire)
    else $error("input transaction taken during page drain");

  a_put_into_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    put |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten before transfer");

  a_frame_end_is_page_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_of_frame) |-> out_data_o.last_of_page)
    else $error("frame end flagged on a word that does not close a page");

endmodule

// File: hw/rtl/mbrpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrpt_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mbrpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/mbrpt_col_asm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrpt_col_asm
// scatters the bits of one row byte into the eight column bytes of a word
// ----------------------------------------------------------------------------
module mbrpt_col_asm (
  input  logic                      clk_i,
  input  mbrpt_pkg::mbrpt_asm_ctrl_t ctrl_i,
  input  logic [7:0]                row_byte_i,
  output logic [63:0]               word_o
);

  import mbrpt_pkg::*;

  logic [63:0] word_q, word_d;

  // column c takes pixel 7-c of the row (msb is leftmost) at bit position row
  always_comb begin
    word_d = word_q;
    for (int c = 0; c < 8; c++) begin
      word_d[{3'(c), ctrl_i.row}] = row_byte_i[7 - c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

// File: hw/rtl/mbrpt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrpt_seq
// frame position tracking and page drain sequencer
// ----------------------------------------------------------------------------
module mbrpt_seq #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_fire_i,
  input  logic                                     frame_start_i,
  input  logic                                     slot_free_i,
  output logic                                     busy_o,
  output logic                                     we_o,
  output logic [$clog2((COLUMNS/8)*8)-1:0]         waddr_o,
  output logic                                     re_o,
  output logic [$clog2((COLUMNS/8)*8)-1:0]         raddr_o,
  output mbrpt_pkg::mbrpt_asm_ctrl_t               asm_ctrl_o,
  output logic                                     put_o,
  output mbrpt_pkg::mbrpt_meta_t                   meta_o
);

  import mbrpt_pkg::*;

  localparam int unsigned RowBytes  = COLUMNS / 8;
  localparam int unsigned PageBytes = RowBytes * RowsPerPage;
  localparam int unsigned AW = $clog2(PageBytes);
  localparam int unsigned PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned GW = (RowBytes > 1) ? $clog2(RowBytes) : 1;

  localparam logic [AW-1:0] LastOff  = AW'(PageBytes - 1);
  localparam logic [AW-1:0] RowStep  = AW'(RowBytes);
  localparam logic [PW-1:0] LastPage = PW'(PAGES - 1);
  localparam logic [GW-1:0] LastGrp  = GW'(RowBytes - 1);

  mbrpt_state_e  state_q, state_d;
  logic [AW-1:0] offset_q, offset_d;
  logic [PW-1:0] page_q, page_d;
  logic [PW-1:0] out_page_q, out_page_d;
  logic          frame_end_q, frame_end_d;
  logic [GW-1:0] group_q, group_d;
  logic [2:0]    row_q, row_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          rd_vld_q;
  logic [2:0]    rd_row_q;

  logic [AW-1:0] cur_off;
  logic [PW-1:0] cur_page;
  logic [PW+2:0] page_ext;
  logic [GW+3:0] group_ext;

  assign cur_off  = frame_start_i ? '0 : offset_q;
  assign cur_page = frame_start_i ? '0 : page_q;

  always_comb begin
    state_d     = state_q;
    offset_d    = offset_q;
    page_d      = page_q;
    out_page_d  = out_page_q;
    frame_end_d = frame_end_q;
    group_d     = group_q;
    row_d       = row_q;
    addr_d      = addr_q;
    we_o        = 1'b0;
    re_o        = 1'b0;
    put_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          we_o = 1'b1;
          if (cur_off == LastOff) begin
            offset_d    = '0;
            page_d      = (cur_page == LastPage) ? '0 : cur_page + PW'(1);
            out_page_d  = cur_page;
            frame_end_d = (cur_page == LastPage);
            group_d     = '0;
            row_d       = '0;
            addr_d      = '0;
            state_d     = ST_READ;
          end else begin
            offset_d = cur_off + AW'(1);
            page_d   = cur_page;
          end
        end
      end
      ST_READ: begin
        re_o   = 1'b1;
        addr_d = addr_q + RowStep;
        row_d  = row_q + 3'd1;
        if (row_q == 3'd7) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_PUT;
      end
      ST_PUT: begin
        if (slot_free_i) begin
          put_o = 1'b1;
          if (group_q == LastGrp) begin
            state_d = ST_IDLE;
          end else begin
            group_d = group_q + GW'(1);
            addr_d  = AW'(group_q + GW'(1));
            row_d   = '0;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      offset_q    <= '0;
      page_q      <= '0;
      out_page_q  <= '0;
      frame_end_q <= 1'b0;
      group_q     <= '0;
      row_q       <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_row_q    <= '0;
    end else begin
      state_q     <= state_d;
      offset_q    <= offset_d;
      page_q      <= page_d;
      out_page_q  <= out_page_d;
      frame_end_q <= frame_end_d;
      group_q     <= group_d;
      row_q       <= row_d;
      addr_q      <= addr_d;
      rd_vld_q    <= re_o;
      rd_row_q    <= row_q;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign waddr_o = cur_off;
  assign raddr_o = addr_q;

  assign asm_ctrl_o.load = rd_vld_q;
  assign asm_ctrl_o.row  = rd_row_q;

  // indexes are masked to the field widths
  assign page_ext  = {3'b000, out_page_q};
  assign group_ext = {4'b0000, group_q};

  assign meta_o.page_index    = page_ext[2:0];
  assign meta_o.group_index   = group_ext[3:0];
  assign meta_o.last_of_page  = (group_q == LastGrp);
  assign meta_o.last_of_frame = (group_q == LastGrp) && frame_end_q;

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we_o && re_o))
    else $error("buffer written and read in the same cycle");

  a_row7_then_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && row_q == 3'd7) |=> (state_q == ST_LAST && rd_vld_q))
    else $error("last row read not followed by assembly");

  a_put_needs_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_o |-> slot_free_i)
    else $error("word handed over while output register is full");

  a_offset_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q <= LastOff)
    else $error("byte offset beyond page");

  a_write_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |=> (state_q == ST_IDLE || (state_q == ST_READ && row_q == 3'd0)))
    else $error("buffer write outside of fill phase");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bitmap row-to-page transpose block
// ----------------------------------------------------------------------------
// Drives row-major pixel bytes into the block and compares every column word
// with a local page predictor. A directed run comes first. It sends one page
// whose column words can be read off by eye, then a partial page and two
// back-to-back restarts. Random bytes follow. They carry on from the
// restarted page and close two more pages. Sender gaps and receiver stalls
// change from phase to phase. One long receiver hold-off backs the block up
// into its input.
// ----------------------------------------------------------------------------
module tb_top;
  import mbrpt_pkg::*;

  localparam int unsigned COLUMNS     = 128;
  localparam int unsigned PAGES       = 8;
  localparam int unsigned ROW_BYTES   = COLUMNS / 8;
  localparam int unsigned PAGE_BYTES  = ROW_BYTES * RowsPerPage;
  localparam int unsigned FRAME_BYTES = PAGE_BYTES * PAGES;

  localparam int unsigned RAND_ITEMS   = 260;
  localparam int unsigned PHASE_ITEMS  = 65;
  localparam int unsigned HOLD_AT      = 240;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 20000;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned MAX_PRINTS   = 100;

  // how a directed row builds its run of pixel bytes
  typedef enum logic [1:0] {
    FILL_CONST,      // every byte is the fill value
    FILL_RAND,       // random bytes, checked against the predictor
    FILL_TOP_ROW,    // first row of the run gets the fill value, rest zero
    FILL_BOTTOM_ROW  // last row of the run gets the fill value, rest zero
  } fill_mode_e;

  typedef struct packed {
    fill_mode_e  mode;
    logic [7:0]  fill;
    logic        start;       // frame_start on the first byte of the run
    logic [10:0] nbytes;
    logic        fixed_on;    // column word typed in below
    logic [63:0] fixed_word;  // same for every group of the page
  } dir_row_t;

  localparam int unsigned DIR_COUNT = 4;

  // page 0 carries only the leftmost pixel of each byte, so column 0 is all
  // ones; then part of page 1 and two restarts in a row
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{FILL_CONST,      8'h80, 1'b1, 11'd128, 1'b1, 64'h0000_0000_0000_00FF},
    '{FILL_RAND,       8'h00, 1'b0, 11'd40,  1'b0, 64'h0},
    '{FILL_RAND,       8'h00, 1'b1, 11'd1,   1'b0, 64'h0},
    '{FILL_RAND,       8'h00, 1'b1, 11'd1,   1'b0, 64'h0}
  };

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  mbrpt_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  mbrpt_out_t out_data;

  // predictor state: one page of row bytes and the position in the frame
  logic [7:0]   page_buf [PAGE_BYTES];
  int unsigned  frame_pos   = 0;
  mbrpt_out_t   col_word_q [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  logic        hold_req        = 1'b0;
  int unsigned hold_left       = 0;
  int unsigned err_cnt         = 0;
  int unsigned cycle_cnt       = 0;

  mono_bitmap_row_to_page_transpose_top #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_cnt, what, got, want);
    end
  endtask

  // stores one accepted byte; the last byte of a page queues its column words
  task automatic predict_page_words(input mbrpt_in_t item, input logic fixed_on,
                                    input logic [63:0] fixed_word);
    mbrpt_out_t  word;
    logic [63:0] cols;
    int unsigned offset;
    int unsigned page_no;
    int unsigned g;
    int unsigned c;
    int unsigned r;
    if (item.frame_start) begin
      frame_pos = 0;
    end
    offset  = frame_pos % PAGE_BYTES;
    page_no = frame_pos / PAGE_BYTES;
    page_buf[offset] = item.pixel_byte;
    if (offset == PAGE_BYTES - 1) begin
      for (g = 0; g < ROW_BYTES; g++) begin
        cols = '0;
        // leftmost pixel (msb) is column 0; top row lands in the lsb
        for (c = 0; c < 8; c++) begin
          for (r = 0; r < RowsPerPage; r++) begin
            cols[8 * c + r] = page_buf[r * ROW_BYTES + g][7 - c];
          end
        end
        word.column_bytes  = fixed_on ? fixed_word : cols;
        word.page_index    = 3'(page_no);
        word.group_index   = 4'(g);
        word.last_of_page  = (g == ROW_BYTES - 1);
        word.last_of_frame = (g == ROW_BYTES - 1) && (page_no == PAGES - 1);
        col_word_q.push_back(word);
      end
    end
    frame_pos = (frame_pos + 1) % FRAME_BYTES;
  endtask

  task automatic check_column_word(input mbrpt_out_t got);
    mbrpt_out_t want;
    if (col_word_q.size() == 0) begin
      report_mismatch("column word with none pending", got.column_bytes, '0);
    end else begin
      want = col_word_q.pop_front();
      if (got.column_bytes !== want.column_bytes) begin
        report_mismatch("column_bytes", got.column_bytes, want.column_bytes);
      end
      if (got.page_index !== want.page_index) begin
        report_mismatch("page_index", 64'(got.page_index), 64'(want.page_index));
      end
      if (got.group_index !== want.group_index) begin
        report_mismatch("group_index", 64'(got.group_index), 64'(want.group_index));
      end
      if (got.last_of_page !== want.last_of_page) begin
        report_mismatch("last_of_page", 64'(got.last_of_page), 64'(want.last_of_page));
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        report_mismatch("last_of_frame", 64'(got.last_of_frame), 64'(want.last_of_frame));
      end
    end
  endtask

  // offers one byte after a random gap and holds it until the block takes it;
  // returns at the edge of acceptance with valid still high
  task automatic send_pixel_byte(input logic [7:0] pix, input logic start,
                                 input logic fixed_on, input logic [63:0] fixed_word);
    mbrpt_in_t item;
    item.pixel_byte  = pix;
    item.frame_start = start;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    predict_page_words(item, fixed_on, fixed_word);
  endtask

  // lowers valid and waits until every queued column word has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (col_word_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  // output side: checks every column word transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      check_column_word(out_data);
    end
  end

  // receiver: random stalls, or one long hold-off counted here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    int unsigned k;
    int unsigned rand_items;
    int unsigned waited;
    dir_row_t    dr;
    logic [7:0]  pix;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pages, no idling on either side
    for (row = 0; row < DIR_COUNT; row++) begin
      dr = DIR_ROWS[row];
      for (k = 0; k < dr.nbytes; k++) begin
        case (dr.mode)
          FILL_CONST:      pix = dr.fill;
          FILL_TOP_ROW:    pix = (k < ROW_BYTES) ? dr.fill : 8'h00;
          FILL_BOTTOM_ROW: pix = (k >= dr.nbytes - ROW_BYTES) ? dr.fill : 8'h00;
          default:         pix = 8'($urandom_range(255));
        endcase
        send_pixel_byte(pix, dr.start && (k == 0), dr.fixed_on, dr.fixed_word);
      end
    end

    // random bytes: finish the restarted page, fill the next one and start
    // a third one that waits in the stalled input during the hold-off
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items % PHASE_ITEMS == 0) begin
        // phase change: sender pauses until every column word has come out
        wait_for_drain();
        case ((rand_items / PHASE_ITEMS) % 4)
          0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin sender_idle_pct = 0;  recv_stall_pct = 46; end
          2: begin sender_idle_pct = 46; recv_stall_pct = 0;  end
          default: begin sender_idle_pct = 8; recv_stall_pct = 8; end
        endcase
      end
      // long hold-off shortly before a page ends, while bytes keep coming
      if (rand_items == HOLD_AT) begin
        hold_req = 1'b1;
      end
      case ($urandom_range(9))
        0:       pix = 8'h00;
        1:       pix = 8'hFF;
        default: pix = 8'($urandom_range(255));
      endcase
      send_pixel_byte(pix, 1'b0, 1'b0, '0);
      rand_items++;
    end
    in_valid <= 1'b0;

    waited = 0;
    while (col_word_q.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    if (col_word_q.size() != 0) begin
      report_mismatch("column words never produced", 64'(col_word_q.size()), '0);
    end
    // nothing is left in flight once the last word is out; a short margin
    repeat (40) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mbrpt_pkg.sv
hw/rtl/mbrpt_ram.sv
hw/rtl/mbrpt_col_asm.sv
hw/rtl/mbrpt_seq.sv
hw/rtl/mono_bitmap_row_to_page_transpose_top.sv
verif/tb_top.sv
